>>> sv/scc_pkg.sv
// shared types and codes for the component search engine
`default_nettype none
package scc_pkg;
   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_RUN   = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_FRAME,
      ST_SCAN,
      ST_EDGE,
      ST_TGT,
      ST_FIN,
      ST_POP,
      ST_POPRD,
      ST_EMIT,
      ST_PARENT,
      ST_LAST
   } state_type;
endpackage
`default_nettype wire

>>> sv/scc_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module scc_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> sv/strongly_connected_components_top.sv
// top level of the tarjan component search engine
//
// req channel: one word per command (add edge, run search, clear graph),
// valid/stall handshake. rsp channel: one word per node popped into a
// component, with its root, a last flag on the final word of a run and the
// sticky edge overflow flag. csr channel: valid/ready write of the walk's
// first node, taken only while the engine is idle.
// An add or clear word is taken and the next word may follow
// at once. A run raises req_stall from the cycle after it is taken until the
// walk is done. The walk starts, then reads a frame for each newly reached
// node and each resume after a matching edge, scans edge entries (registered
// read, then compare), writes a child frame per newly reached node, and
// finishes nodes and emits results.
// The engine handles one word at a time. Results sit in one output register,
// so a stalled receiver holds the walk in its emit step until the word is
// taken. Synchronous reset empties the edge table, clears the overflow flag
// and sets the first node to 1; there is no clearing pass, per-node visit
// state is cleared by valid bits at run start.
`default_nettype none
module strongly_connected_components_top #(
   parameter int NODES = 16,
   parameter int EDGES = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_func,
   input  wire logic [3:0] req_edge_source,
   input  wire logic [3:0] req_edge_target,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [3:0]      rsp_member_node,
   output logic [3:0]      rsp_component_root,
   output logic            rsp_is_last,
   output logic            rsp_edges_dropped,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [3:0] csr_first_node
);
   localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int EW = (EDGES > 1) ? $clog2(EDGES) : 1;
   localparam int CW = $clog2(EDGES + 1);
   localparam int DW = $clog2(NODES + 1);   // visit numbers, stack pointers

   scc_pkg::state_type state_ff, state_in;

   logic [CW-1:0] ecount_ff, ecount_in;
   logic          ovf_ff, ovf_in;
   logic [3:0]    start_ff;
   logic [DW-1:0] vcnt_ff, vcnt_in;
   logic [DW-1:0] sp_ff, sp_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [NW-1:0] n_ff, n_in;
   logic [CW-1:0] e_ff, e_in;
   logic [NW-1:0] x_ff, x_in;
   logic [NW-1:0] w_ff, w_in;
   logic          grow_ff, grow_in;

   // per-node visit state in flip-flops (few nodes, fixed read places)
   logic [DW-1:0] disc_ff [NODES];
   logic [DW-1:0] low_ff [NODES];
   logic [NODES-1:0] onst_ff;
   logic [NODES-1:0] vis_ff;

   logic          rv_ff;
   logic [3:0]    rm_ff, rr_ff;
   logic          rl_ff, rd_ff;

   // memory ports
   logic          ed_we;
   logic [EW-1:0] ed_wa, ed_ra;
   logic [2*NW-1:0] ed_wd, ed_rd;
   logic          st_we;
   logic [NW-1:0] st_wa, st_ra, st_rd, st_wd;
   logic          fr_we;
   logic [NW-1:0] fr_wa, fr_ra;
   logic [NW+CW-1:0] fr_wd, fr_rd;

   logic [NW-1:0] ed_src, ed_tgt;
   logic [NW-1:0] fr_rd_parent;

   logic req_acc, rsp_free;
   logic in_range;
   logic visit_now;      // discover node in visit_node
   logic [NW-1:0] visit_node;
   logic low_wr;
   logic [NW-1:0] low_idx;
   logic [DW-1:0] low_val;
   logic pop_clr;
   logic emit;
   logic emit_last;

   scc_ram #(.WIDTH(2*NW), .DEPTH(EDGES)) u_edges (
      .clock(clock), .wr_en(ed_we), .wr_addr(ed_wa), .wr_data(ed_wd),
      .rd_addr(ed_ra), .rd_data(ed_rd));
   scc_ram #(.WIDTH(NW), .DEPTH(NODES)) u_stack (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(st_ra), .rd_data(st_rd));
   scc_ram #(.WIDTH(NW + CW), .DEPTH(NODES)) u_frames (
      .clock(clock), .wr_en(fr_we), .wr_addr(fr_wa), .wr_data(fr_wd),
      .rd_addr(fr_ra), .rd_data(fr_rd));

   assign req_stall = (state_ff != scc_pkg::ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = (state_ff == scc_pkg::ST_IDLE);
   assign rsp_free  = !rv_ff || !rsp_stall;
   assign in_range  = (32'(req_edge_source) < NODES) && (32'(req_edge_target) < NODES);
   assign ed_src    = ed_rd[2*NW-1:NW];
   assign ed_tgt    = ed_rd[NW-1:0];
   assign st_wd     = visit_node;
   // parent frame sits at depth-1 once the child frame is popped
   assign fr_rd_parent = fr_rd[NW+CW-1:CW];

   // next state and datapath control
   always_comb begin
      state_in = state_ff;
      ecount_in = ecount_ff;
      ovf_in = ovf_ff;
      vcnt_in = vcnt_ff;
      sp_in = sp_ff;
      depth_in = depth_ff;
      n_in = n_ff;
      e_in = e_ff;
      x_in = x_ff;
      w_in = w_ff;
      grow_in = grow_ff;
      ed_we = 1'b0;
      ed_wa = ecount_ff[EW-1:0];
      ed_wd = {NW'(req_edge_source), NW'(req_edge_target)};
      ed_ra = e_ff[EW-1:0];
      st_we = 1'b0;
      st_wa = sp_ff[NW-1:0];
      st_ra = NW'(sp_ff - DW'(1));
      fr_we = 1'b0;
      fr_wa = NW'(depth_ff - DW'(1));
      fr_wd = {n_ff, e_ff};
      fr_ra = NW'(depth_ff - DW'(1));
      visit_now = 1'b0;
      visit_node = x_ff;
      low_wr = 1'b0;
      low_idx = n_ff;
      low_val = '0;
      pop_clr = 1'b0;
      emit = 1'b0;
      emit_last = 1'b0;
      case (state_ff)
         scc_pkg::ST_IDLE: begin
            if (req_acc) begin
               case (scc_pkg::func_type'(req_func))
                  scc_pkg::FUNC_ADD: begin
                     if (in_range) begin
                        if (32'(ecount_ff) >= EDGES) begin
                           ovf_in = 1'b1;
                        end else begin
                           ed_we = 1'b1;
                           ecount_in = ecount_ff + CW'(1);
                        end
                     end
                  end
                  scc_pkg::FUNC_RUN: begin
                     vcnt_in = '0;
                     sp_in = '0;
                     depth_in = '0;
                     state_in = scc_pkg::ST_INIT;
                  end
                  scc_pkg::FUNC_CLEAR: begin
                     ecount_in = '0;
                     ovf_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // visit the first node and push its frame; no walk when out of range
         scc_pkg::ST_INIT: begin
            if (32'(start_ff) < NODES) begin
               visit_node = NW'(start_ff);
               visit_now = 1'b1;
               st_we = 1'b1;
               sp_in = sp_ff + DW'(1);
               vcnt_in = vcnt_ff + DW'(1);
               fr_we = 1'b1;
               fr_wa = '0;
               fr_wd = {NW'(start_ff), CW'(0)};
               depth_in = DW'(1);
               state_in = scc_pkg::ST_FRAME;
            end else begin
               state_in = scc_pkg::ST_IDLE;
            end
         end
         // top frame read issued; capture it next
         scc_pkg::ST_FRAME: begin
            state_in = scc_pkg::ST_SCAN;
         end
         scc_pkg::ST_SCAN: begin
            n_in = fr_rd[NW+CW-1:CW];
            e_in = fr_rd[CW-1:0];
            state_in = scc_pkg::ST_EDGE;
         end
         // issue read of edge e, check it next cycle; past the last edge, finish the frame
         scc_pkg::ST_EDGE: begin
            if (e_ff < ecount_ff) begin
               state_in = scc_pkg::ST_TGT;
            end else begin
               depth_in = depth_ff - DW'(1);
               state_in = scc_pkg::ST_FIN;
            end
         end
         scc_pkg::ST_TGT: begin
            if (ed_src != n_ff) begin
               e_in = e_ff + CW'(1);
               state_in = scc_pkg::ST_EDGE;
            end else begin
               x_in = ed_tgt;
               visit_node = ed_tgt;
               fr_we = 1'b1;
               fr_wd = {n_ff, e_ff + CW'(1)};
               if (!vis_ff[ed_tgt]) begin
                  visit_now = 1'b1;
                  vcnt_in = vcnt_ff + DW'(1);
                  if (32'(sp_ff) < NODES) begin
                     st_we = 1'b1;
                     sp_in = sp_ff + DW'(1);
                  end
                  grow_in = (32'(depth_ff) < NODES);
                  if (32'(depth_ff) < NODES) begin
                     depth_in = depth_ff + DW'(1);
                  end
                  state_in = scc_pkg::ST_PARENT;
               end else begin
                  if (onst_ff[ed_tgt] && disc_ff[ed_tgt] < low_ff[n_ff]) begin
                     low_wr = 1'b1;
                     low_val = disc_ff[ed_tgt];
                  end
                  state_in = scc_pkg::ST_FRAME;
               end
            end
         end
         // second write: child frame when the call stack grew
         scc_pkg::ST_PARENT: begin
            if (grow_ff) begin
               fr_we = 1'b1;
               fr_wd = {x_ff, CW'(0)};
            end
            state_in = scc_pkg::ST_FRAME;
         end
         // frame done; pop component if it is a root
         scc_pkg::ST_FIN: begin
            if (low_ff[n_ff] == disc_ff[n_ff] && sp_ff != '0) begin
               state_in = scc_pkg::ST_POP;
            end else begin
               state_in = scc_pkg::ST_LAST;
            end
         end
         scc_pkg::ST_POP: begin
            sp_in = sp_ff - DW'(1);
            state_in = scc_pkg::ST_POPRD;
         end
         scc_pkg::ST_POPRD: begin
            w_in = st_rd;
            pop_clr = 1'b1;
            state_in = scc_pkg::ST_EMIT;
         end
         scc_pkg::ST_EMIT: begin
            if (rsp_free) begin
               emit = 1'b1;
               emit_last = (w_ff == n_ff || sp_ff == '0) && depth_ff == '0;
               if (w_ff == n_ff || sp_ff == '0) begin
                  state_in = scc_pkg::ST_LAST;
               end else begin
                  state_in = scc_pkg::ST_POP;
               end
            end
         end
         // propagate low to parent, resume parent or finish
         scc_pkg::ST_LAST: begin
            if (depth_ff == '0) begin
               state_in = scc_pkg::ST_IDLE;
            end else begin
               low_wr = 1'b1;
               low_idx = fr_rd_parent;
               low_val = (low_ff[n_ff] < low_ff[fr_rd_parent]) ? low_ff[n_ff]
                                                              : low_ff[fr_rd_parent];
               state_in = scc_pkg::ST_FRAME;
            end
         end
         default: begin
            state_in = scc_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scc_pkg::ST_IDLE;
         ecount_ff <= '0;
         ovf_ff <= 1'b0;
         start_ff <= 4'd1;
         vcnt_ff <= '0;
         sp_ff <= '0;
         depth_ff <= '0;
         rv_ff <= 1'b0;
         vis_ff <= '0;
         onst_ff <= '0;
      end else begin
         state_ff <= state_in;
         ecount_ff <= ecount_in;
         ovf_ff <= ovf_in;
         vcnt_ff <= vcnt_in;
         sp_ff <= sp_in;
         depth_ff <= depth_in;
         if (csr_valid && csr_ready) begin
            start_ff <= csr_first_node;
         end
         if (state_ff == scc_pkg::ST_IDLE && req_acc
             && scc_pkg::func_type'(req_func) == scc_pkg::FUNC_RUN) begin
            vis_ff <= '0;
            onst_ff <= '0;
         end else begin
            if (visit_now) begin
               vis_ff[visit_node] <= 1'b1;
               onst_ff[visit_node] <= 1'b1;
            end
            if (pop_clr) begin
               onst_ff[st_rd] <= 1'b0;
            end
         end
         if (emit) begin
            rv_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rv_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff <= n_in;
      e_ff <= e_in;
      x_ff <= x_in;
      w_ff <= w_in;
      grow_ff <= grow_in;
      if (visit_now) begin
         disc_ff[visit_node] <= vcnt_ff + DW'(1);
         low_ff[visit_node] <= vcnt_ff + DW'(1);
      end
      if (low_wr) begin
         low_ff[low_idx] <= low_val;
      end
      if (emit) begin
         rm_ff <= 4'(w_ff);
         rr_ff <= 4'(n_ff);
         rl_ff <= emit_last;
         rd_ff <= ovf_ff;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_member_node = rm_ff;
   assign rsp_component_root = rr_ff;
   assign rsp_is_last = rl_ff;
   assign rsp_edges_dropped = rd_ff;

   // checks
   a_no_emit_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == scc_pkg::ST_IDLE |-> !emit) else $error("emit while idle");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_stall |=> rv_ff) else $error("result lost under stall");
   a_sp: assert property (@(posedge clock) disable iff (reset)
      32'(sp_ff) <= NODES) else $error("stack pointer overrun");
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !req_stall) else $error("csr write while busy");
endmodule
`default_nettype wire
